/* rtl/vssd_pkg.sv */
// ----------------------------------------------------------------------------
// vssd_pkg
// shared constants, register codes and control structs for the sag/swell
// detector
// ----------------------------------------------------------------------------
package vssd_pkg;

  // default widths
  localparam int MagBitsDefault    = 24;
  localparam int LengthBitsDefault = 16;

  // fixed register widths
  localparam int HoldBits   = 10;
  localparam int PhaseBits  = 2;
  localparam int NumPhases  = 3;
  localparam int CfgAddrBits = 3;

  // register indexes
  localparam logic [CfgAddrBits-1:0] RegSwellThreshold = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegSagHigh        = 3'd1;
  localparam logic [CfgAddrBits-1:0] RegSagLow         = 3'd2;
  localparam logic [CfgAddrBits-1:0] RegSwellHold      = 3'd3;
  localparam logic [CfgAddrBits-1:0] RegSagHold        = 3'd4;
  localparam logic [CfgAddrBits-1:0] RegPhaseCount     = 3'd5;

  // reset values
  localparam logic [HoldBits-1:0]  SwellHoldReset  = 10'd100;
  localparam logic [HoldBits-1:0]  SagHoldReset    = 10'd300;
  localparam logic [PhaseBits-1:0] PhaseCountReset = 2'd3;

  // detection flags for one window
  typedef struct packed {
    logic swell;
    logic sag;
  } found_t;

  // per-detector event flags for one window
  typedef struct packed {
    logic active;
    logic start;
    logic ending;
  } evt_flags_t;

endpackage

/* rtl/vssd_compare.sv */
// ----------------------------------------------------------------------------
// vssd_compare
// per-phase threshold and band compares, or-reduced over the active phases
// ----------------------------------------------------------------------------
module vssd_compare #(
  parameter int MAG_BITS = vssd_pkg::MagBitsDefault
) (
  input  logic [MAG_BITS-1:0]            mag [vssd_pkg::NumPhases],
  input  logic [MAG_BITS-1:0]            swell_threshold,
  input  logic [MAG_BITS-1:0]            sag_high,
  input  logic [MAG_BITS-1:0]            sag_low,
  input  logic [vssd_pkg::PhaseBits-1:0] phase_count,
  output vssd_pkg::found_t               found
);

  logic [vssd_pkg::NumPhases-1:0] swell_hit;
  logic [vssd_pkg::NumPhases-1:0] sag_hit;

  for (genvar i = 0; i < vssd_pkg::NumPhases; i++) begin : g_phase
    logic phase_en;
    assign phase_en     = phase_count > vssd_pkg::PhaseBits'(i);
    assign swell_hit[i] = phase_en && (mag[i] > swell_threshold);
    assign sag_hit[i]   = phase_en && (mag[i] < sag_high) && (mag[i] > sag_low);
  end

  assign found.swell = |swell_hit;
  assign found.sag   = |sag_hit;

endmodule

/* rtl/vssd_event.sv */
// ----------------------------------------------------------------------------
// vssd_event
// one event tracker: start on detection, post-event hold count, end and
// saturating length
// ----------------------------------------------------------------------------
module vssd_event #(
  parameter int LENGTH_BITS = vssd_pkg::LengthBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          found,
  input  logic [vssd_pkg::HoldBits-1:0] hold,
  output vssd_pkg::evt_flags_t          flags,
  output logic [LENGTH_BITS-1:0]        length
);

  logic                          on;
  logic                          on_next;
  logic [vssd_pkg::HoldBits-1:0] post_count;
  logic [vssd_pkg::HoldBits-1:0] post_count_next;
  logic [LENGTH_BITS-1:0]        windows;
  logic [LENGTH_BITS-1:0]        windows_next;

  always_comb begin
    on_next         = on;
    post_count_next = post_count;
    windows_next    = windows;
    flags.start     = 1'b0;
    flags.ending    = 1'b0;
    length          = '0;
    if (on) begin
      // saturating window count, includes the ending window
      if (windows != '1) begin
        windows_next = windows + LENGTH_BITS'(1);
      end
      if (!found) begin
        if (post_count < hold) begin
          post_count_next = post_count + vssd_pkg::HoldBits'(1);
        end else begin
          on_next      = 1'b0;
          flags.ending = 1'b1;
          length       = windows_next;
        end
      end
    end else if (found) begin
      on_next         = 1'b1;
      post_count_next = '0;
      windows_next    = '0;
      flags.start     = 1'b1;
    end
    flags.active = on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on         <= 1'b0;
      post_count <= '0;
      windows    <= '0;
    end else if (advance) begin
      on         <= on_next;
      post_count <= post_count_next;
      windows    <= windows_next;
    end
  end

endmodule

/* rtl/voltage_sag_swell_detector.sv */
// ----------------------------------------------------------------------------
// voltage_sag_swell_detector
// sag and swell event detection over per-window phase magnitudes
// ----------------------------------------------------------------------------
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tdata: mag_a, mag_b, mag_c
// m_axis    out        tdata: swell_active, swell_start, swell_end,
//                             swell_length, sag_active, sag_start, sag_end,
//                             sag_length
// cfg       in         cfg_we / cfg_addr / cfg_wdata, write only
//
// one word per cycle sustained while m_axis_tready stays high; a word that is
// taken passes through the input register, then compare and event update into
// the result register
// reset (rst, synchronous) clears both event trackers, empties both stages
// and restores register defaults
// a stalled result holds in the output register while the input register
// still takes one more word; both stages move together as the result drains
//
module voltage_sag_swell_detector #(
  parameter int MAG_BITS    = vssd_pkg::MagBitsDefault,
  parameter int LENGTH_BITS = vssd_pkg::LengthBitsDefault
) (
  input  logic clk,
  input  logic rst,

  // mag_a, mag_b, mag_c, zero pad to whole bytes
  input  logic [((vssd_pkg::NumPhases*MAG_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,

  // swell_active, swell_start, swell_end, swell_length,
  // sag_active, sag_start, sag_end, sag_length, zero pad to whole bytes
  output logic [((6+2*LENGTH_BITS+7)/8)*8-1:0]              m_axis_tdata,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,

  input  logic                                                   cfg_we,
  input  logic [vssd_pkg::CfgAddrBits-1:0]                       cfg_addr,
  input  logic [((MAG_BITS > vssd_pkg::HoldBits) ?
                 MAG_BITS : vssd_pkg::HoldBits)-1:0]             cfg_wdata
);

  localparam int OutBits = 6 + 2 * LENGTH_BITS;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  // configuration registers
  logic [MAG_BITS-1:0]            swell_threshold;
  logic [MAG_BITS-1:0]            sag_high;
  logic [MAG_BITS-1:0]            sag_low;
  logic [vssd_pkg::HoldBits-1:0]  swell_hold;
  logic [vssd_pkg::HoldBits-1:0]  sag_hold;
  logic [vssd_pkg::PhaseBits-1:0] phase_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      swell_threshold <= '1;
      sag_high        <= '0;
      sag_low         <= '0;
      swell_hold      <= vssd_pkg::SwellHoldReset;
      sag_hold        <= vssd_pkg::SagHoldReset;
      phase_count     <= vssd_pkg::PhaseCountReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        vssd_pkg::RegSwellThreshold: swell_threshold <= cfg_wdata[MAG_BITS-1:0];
        vssd_pkg::RegSagHigh:        sag_high        <= cfg_wdata[MAG_BITS-1:0];
        vssd_pkg::RegSagLow:         sag_low         <= cfg_wdata[MAG_BITS-1:0];
        vssd_pkg::RegSwellHold:      swell_hold  <= cfg_wdata[vssd_pkg::HoldBits-1:0];
        vssd_pkg::RegSagHold:        sag_hold    <= cfg_wdata[vssd_pkg::HoldBits-1:0];
        vssd_pkg::RegPhaseCount:     phase_count <= cfg_wdata[vssd_pkg::PhaseBits-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // stage control: the input stage moves whenever the result register is
  // free or being drained this cycle
  logic in_valid;
  logic advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  logic [MAG_BITS-1:0] in_mag [vssd_pkg::NumPhases];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  for (genvar i = 0; i < vssd_pkg::NumPhases; i++) begin : g_in
    always_ff @(posedge clk) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_mag[i] <= s_axis_tdata[i*MAG_BITS +: MAG_BITS];
      end
    end
  end

  // phase compares
  vssd_pkg::found_t found;

  vssd_compare #(
    .MAG_BITS (MAG_BITS)
  ) u_compare (
    .mag             (in_mag),
    .swell_threshold (swell_threshold),
    .sag_high        (sag_high),
    .sag_low         (sag_low),
    .phase_count     (phase_count),
    .found           (found)
  );

  // event trackers, state steps only when a word moves to the result stage
  vssd_pkg::evt_flags_t   swell_flags;
  vssd_pkg::evt_flags_t   sag_flags;
  logic [LENGTH_BITS-1:0] swell_length;
  logic [LENGTH_BITS-1:0] sag_length;

  vssd_event #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_swell (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .found   (found.swell),
    .hold    (swell_hold),
    .flags   (swell_flags),
    .length  (swell_length)
  );

  vssd_event #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_sag (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .found   (found.sag),
    .hold    (sag_hold),
    .flags   (sag_flags),
    .length  (sag_length)
  );

  // result word, packed lowest field first
  logic [OutBits-1:0] out_packed;

  assign out_packed = {sag_length, sag_flags.ending, sag_flags.start, sag_flags.active,
                       swell_length, swell_flags.ending, swell_flags.start,
                       swell_flags.active};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= OutW'(out_packed);
    end
  end

endmodule

/* rtl/vssd_checker.sv */
// ----------------------------------------------------------------------------
// vssd_checker
// port-level checks on result words of the sag/swell detector
// ----------------------------------------------------------------------------
module vssd_checker #(
  parameter int LENGTH_BITS = vssd_pkg::LengthBitsDefault
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic [((6+2*LENGTH_BITS+7)/8)*8-1:0]  m_axis_tdata,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready
);

  localparam int SagBase = 3 + LENGTH_BITS;

  // stalled word stays put
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a window cannot both start and end the same event
  a_start_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]) &&
                      !(m_axis_tdata[SagBase+1] && m_axis_tdata[SagBase+2]))
    else $error("start and end in one word");

  // length reported only on the ending word
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[2] || m_axis_tdata[3 +: LENGTH_BITS] == '0) &&
      (m_axis_tdata[SagBase+2] || m_axis_tdata[SagBase+3 +: LENGTH_BITS] == '0))
    else $error("length set outside event end");

  // start leaves the event active, end leaves it inactive
  a_active_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (!m_axis_tdata[1] || m_axis_tdata[0]) && (!m_axis_tdata[2] || !m_axis_tdata[0]) &&
      (!m_axis_tdata[SagBase+1] || m_axis_tdata[SagBase]) &&
      (!m_axis_tdata[SagBase+2] || !m_axis_tdata[SagBase]))
    else $error("active flag disagrees with start or end");

endmodule

bind voltage_sag_swell_detector vssd_checker #(
  .LENGTH_BITS (LENGTH_BITS)
) u_vssd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the voltage sag/swell detector: a short table of
// directed windows, then random phases with fresh register settings. every
// window's event report is predicted in the bench or taken from the table and
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MagW    = vssd_pkg::MagBitsDefault;
  localparam int LenW    = vssd_pkg::LengthBitsDefault;
  localparam int InW     = ((vssd_pkg::NumPhases*MagW+7)/8)*8;
  localparam int OutW    = ((6+2*LenW+7)/8)*8;
  localparam int CfgW    = (MagW > vssd_pkg::HoldBits) ? MagW : vssd_pkg::HoldBits;
  localparam int HalfPer = 6;
  localparam int Limit   = 2000;        // cycles without any word moving
  localparam int RandomWindows = 1150;

  localparam logic [MagW-1:0] MagMax = '1;
  localparam logic [LenW-1:0] LenMax = '1;

  // one event report, laid out as m_axis_tdata (lowest field at bit 0)
  typedef struct packed {
    logic [OutW-6-2*LenW-1:0] pad;
    logic [LenW-1:0]          sag_length;
    logic                     sag_end;
    logic                     sag_start;
    logic                     sag_active;
    logic [LenW-1:0]          swell_length;
    logic                     swell_end;
    logic                     swell_start;
    logic                     swell_active;
  } report_t;

  // one event tracker (swell or sag)
  typedef struct packed {
    logic                          on;
    logic [vssd_pkg::HoldBits-1:0] post;
    logic [LenW-1:0]               windows;
  } tracker_t;

  typedef struct packed {
    logic [MagW-1:0]                thr;
    logic [MagW-1:0]                sag_hi;
    logic [MagW-1:0]                sag_lo;
    logic [vssd_pkg::HoldBits-1:0]  swell_hold;
    logic [vssd_pkg::HoldBits-1:0]  sag_hold;
    logic [vssd_pkg::PhaseBits-1:0] phases;
  } det_regs_t;

  typedef enum logic {ROW_REG, ROW_WINDOW} row_kind_e;

  // one line of the directed table: a register write or a window
  typedef struct packed {
    row_kind_e                        kind;
    logic [vssd_pkg::CfgAddrBits-1:0] addr;
    logic [CfgW-1:0]                  value;
    logic [MagW-1:0]                  a;
    logic [MagW-1:0]                  b;
    logic [MagW-1:0]                  c;
    logic                             typed;    // report below is the expectation
    report_t                          report;
  } row_t;

  typedef enum {MOOD_QUIET, MOOD_SWELL, MOOD_SAG, MOOD_BOTH, MOOD_NOISE} mood_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [InW-1:0]                   s_axis_tdata  = '0;   // mag_a, mag_b, mag_c
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [OutW-1:0]                  m_axis_tdata;         // see report_t, lowest first
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic                             cfg_we        = 1'b0;
  logic [vssd_pkg::CfgAddrBits-1:0] cfg_addr      = '0;
  logic [CfgW-1:0]                  cfg_wdata     = '0;

  always #(HalfPer) clk = ~clk;

  voltage_sag_swell_detector #(
    .MAG_BITS    (MagW),
    .LENGTH_BITS (LenW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // bench copy of the registers and both trackers
  det_regs_t regs_now;
  tracker_t  swell_trk;
  tracker_t  sag_trk;

  report_t     awaited_reports[$];
  row_t        stim[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  // idling controls, changed per phase
  logic        src_idle_on  = 1'b1;
  logic        sink_idle_on = 1'b1;
  int unsigned stall_left   = 0;

  mood_e       run_mood = MOOD_QUIET;
  int unsigned run_left = 0;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // one window of one tracker: count up while on, end after the hold runs out
  function automatic tracker_t track_next(tracker_t t, logic found,
                                          logic [vssd_pkg::HoldBits-1:0] hold);
    tracker_t n;
    n = t;
    if (t.on) begin
      if (t.windows != LenMax) n.windows = t.windows + 1'b1;
      if (!found) begin
        if (t.post < hold) n.post = t.post + 1'b1;
        else n.on = 1'b0;
      end
    end else if (found) begin
      n.on      = 1'b1;
      n.post    = '0;
      n.windows = '0;
    end
    return n;
  endfunction

  // advances both trackers by one window and returns its event report
  function automatic report_t predict_events(logic [MagW-1:0] a, logic [MagW-1:0] b,
                                             logic [MagW-1:0] c);
    logic [MagW-1:0] mag [vssd_pkg::NumPhases];
    logic            swell_hit;
    logic            sag_hit;
    tracker_t        sw_n;
    tracker_t        sg_n;
    report_t         r;
    mag[0] = a;
    mag[1] = b;
    mag[2] = c;
    swell_hit = 1'b0;
    sag_hit   = 1'b0;
    // only the first phase_count phases take part
    for (int p = 0; p < vssd_pkg::NumPhases; p++) begin
      if (p < int'(regs_now.phases)) begin
        if (mag[p] > regs_now.thr) swell_hit = 1'b1;
        if (mag[p] < regs_now.sag_hi && mag[p] > regs_now.sag_lo) sag_hit = 1'b1;
      end
    end
    sw_n = track_next(swell_trk, swell_hit, regs_now.swell_hold);
    sg_n = track_next(sag_trk, sag_hit, regs_now.sag_hold);
    r = '0;
    r.swell_active = sw_n.on;
    r.swell_start  = !swell_trk.on && sw_n.on;
    r.swell_end    = swell_trk.on && !sw_n.on;
    r.swell_length = r.swell_end ? sw_n.windows : '0;
    r.sag_active   = sg_n.on;
    r.sag_start    = !sag_trk.on && sg_n.on;
    r.sag_end      = sag_trk.on && !sg_n.on;
    r.sag_length   = r.sag_end ? sg_n.windows : '0;
    swell_trk = sw_n;
    sag_trk   = sg_n;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // table helpers
  // --------------------------------------------------------------------------

  function automatic report_t report(logic sw_act, logic sw_st, logic sw_end,
                                     logic [LenW-1:0] sw_len, logic sg_act,
                                     logic sg_st, logic sg_end, logic [LenW-1:0] sg_len);
    report_t r;
    r = '0;
    r.swell_active = sw_act;
    r.swell_start  = sw_st;
    r.swell_end    = sw_end;
    r.swell_length = sw_len;
    r.sag_active   = sg_act;
    r.sag_start    = sg_st;
    r.sag_end      = sg_end;
    r.sag_length   = sg_len;
    return r;
  endfunction

  function automatic row_t reg_row(logic [vssd_pkg::CfgAddrBits-1:0] addr,
                                   logic [CfgW-1:0] value);
    row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.addr  = addr;
    r.value = value;
    return r;
  endfunction

  function automatic row_t win_row(logic [MagW-1:0] a, logic [MagW-1:0] b,
                                   logic [MagW-1:0] c, logic typed, report_t rep);
    row_t r;
    r        = '0;
    r.kind   = ROW_WINDOW;
    r.a      = a;
    r.b      = b;
    r.c      = c;
    r.typed  = typed;
    r.report = rep;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // random helpers
  // --------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [vssd_pkg::HoldBits-1:0] pick_hold();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    else if (r == 1) return vssd_pkg::HoldBits'($urandom_range(0, 1023));
    else if (r < 5) return '0;
    else return vssd_pkg::HoldBits'($urandom_range(1, 6));
  endfunction

  // short holds dominate so events end often; extremes now and then
  function automatic det_regs_t random_regs();
    det_regs_t r;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // anything goes, empty or inverted sag bands included
      r.thr    = MagW'($urandom);
      r.sag_hi = MagW'($urandom);
      r.sag_lo = MagW'($urandom);
    end else begin
      r.thr    = (pick == 1) ? '0 : (pick == 2) ? MagMax : MagW'($urandom);
      r.sag_hi = (pick == 3) ? MagMax : MagW'($urandom_range(0, r.thr));
      r.sag_lo = (pick == 4) ? '0 : MagW'($urandom_range(0, r.sag_hi));
    end
    r.swell_hold = pick_hold();
    r.sag_hold   = pick_hold();
    pick         = $urandom_range(0, 5);
    r.phases     = (pick > 3) ? vssd_pkg::PhaseBits'(3) : vssd_pkg::PhaseBits'(pick);
    return r;
  endfunction

  // a magnitude that aims at one kind of window under the current settings
  function automatic logic [MagW-1:0] pick_mag(mood_e m);
    logic [MagW-1:0] v;
    v = MagW'($urandom);
    case (m)
      MOOD_SWELL: begin
        if (regs_now.thr != MagMax) v = MagW'($urandom_range(MagMax, regs_now.thr + 1));
      end
      MOOD_SAG: begin
        if (32'(regs_now.sag_lo) + 1 < 32'(regs_now.sag_hi))
          v = MagW'($urandom_range(regs_now.sag_hi - 1, regs_now.sag_lo + 1));
      end
      MOOD_QUIET: begin
        // band edges and threshold itself never trip their own test
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = regs_now.sag_lo;
          2:       v = regs_now.sag_hi;
          default: v = regs_now.thr;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // drivers, all stepping on the falling edge
  // --------------------------------------------------------------------------

  // offers one word; returns at the falling edge after it is taken with
  // tvalid still high, so a following word can go straight out
  task automatic send_word(logic [MagW-1:0] a, logic [MagW-1:0] b, logic [MagW-1:0] c,
                           logic typed, report_t rep);
    int unsigned gap;
    report_t     predicted;
    gap = src_idle_on ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= InW'({c, b, a});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    predicted = predict_events(a, b, c);
    awaited_reports.push_back(typed ? rep : predicted);
  endtask

  // source off, every report back, then let the pipe settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [vssd_pkg::CfgAddrBits-1:0] addr, logic [CfgW-1:0] value);
    cfg_addr  <= addr;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (addr)
      vssd_pkg::RegSwellThreshold: regs_now.thr        = value[MagW-1:0];
      vssd_pkg::RegSagHigh:        regs_now.sag_hi     = value[MagW-1:0];
      vssd_pkg::RegSagLow:         regs_now.sag_lo     = value[MagW-1:0];
      vssd_pkg::RegSwellHold:      regs_now.swell_hold = value[vssd_pkg::HoldBits-1:0];
      vssd_pkg::RegSagHold:        regs_now.sag_hold   = value[vssd_pkg::HoldBits-1:0];
      vssd_pkg::RegPhaseCount:     regs_now.phases     = value[vssd_pkg::PhaseBits-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(det_regs_t r);
    quiesce();
    write_reg(vssd_pkg::RegSwellThreshold, CfgW'(r.thr));
    write_reg(vssd_pkg::RegSagHigh,        CfgW'(r.sag_hi));
    write_reg(vssd_pkg::RegSagLow,         CfgW'(r.sag_lo));
    write_reg(vssd_pkg::RegSwellHold,      CfgW'(r.swell_hold));
    write_reg(vssd_pkg::RegSagHold,        CfgW'(r.sag_hold));
    write_reg(vssd_pkg::RegPhaseCount,     CfgW'(r.phases));
  endtask

  // runs of windows sharing one intent, so events start, hold and end
  task automatic send_random_window();
    logic [MagW-1:0] m [vssd_pkg::NumPhases];
    int unsigned     lead;
    int unsigned     pick;
    if (run_left == 0) begin
      pick = $urandom_range(0, 9);
      run_mood = (pick < 4) ? MOOD_QUIET : (pick < 6) ? MOOD_SWELL :
                 (pick < 8) ? MOOD_SAG : (pick < 9) ? MOOD_BOTH : MOOD_NOISE;
      run_left = $urandom_range(1, 12);
    end
    run_left--;
    lead = (regs_now.phases == 0) ? $urandom_range(0, 2) :
           $urandom_range(0, regs_now.phases - 1);
    // inactive phases carry full-range values, they must not matter
    for (int p = 0; p < vssd_pkg::NumPhases; p++) begin
      if (p >= int'(regs_now.phases) || $urandom_range(0, 4) == 0) m[p] = pick_mag(MOOD_NOISE);
      else m[p] = pick_mag(MOOD_QUIET);
    end
    case (run_mood)
      MOOD_SWELL: m[lead] = pick_mag(MOOD_SWELL);
      MOOD_SAG:   m[lead] = pick_mag(MOOD_SAG);
      MOOD_BOTH: begin
        m[lead]           = pick_mag(MOOD_SWELL);
        m[(lead + 1) % 3] = pick_mag(MOOD_SAG);
      end
      MOOD_NOISE: begin
        for (int p = 0; p < vssd_pkg::NumPhases; p++) m[p] = pick_mag(MOOD_NOISE);
      end
      default: ;
    endcase
    send_word(m[0], m[1], m[2], 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, checking at the rising edge
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_idle_on) stall_left <= gap_len();
    end
  end

  task automatic check_field(string name, logic [LenW-1:0] want, logic [LenW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  report_t got_rep;
  report_t want_rep;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_rep = report_t'(m_axis_tdata);
      if (awaited_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_rep = awaited_reports.pop_front();
        check_field("swell_active", LenW'(want_rep.swell_active), LenW'(got_rep.swell_active));
        check_field("swell_start",  LenW'(want_rep.swell_start),  LenW'(got_rep.swell_start));
        check_field("swell_end",    LenW'(want_rep.swell_end),    LenW'(got_rep.swell_end));
        check_field("swell_length", want_rep.swell_length,        got_rep.swell_length);
        check_field("sag_active",   LenW'(want_rep.sag_active),   LenW'(got_rep.sag_active));
        check_field("sag_start",    LenW'(want_rep.sag_start),    LenW'(got_rep.sag_start));
        check_field("sag_end",      LenW'(want_rep.sag_end),      LenW'(got_rep.sag_end));
        check_field("sag_length",   want_rep.sag_length,          got_rep.sag_length);
        check_field("pad",          LenW'(want_rep.pad),          LenW'(got_rep.pad));
      end
    end
  end

  // watchdog: any word moving on either side counts as progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Limit) begin
        $display("%0t: no word moved for %0d cycles", $time, Limit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_no;
    det_regs_t   r;
    row_t        row;

    // register defaults and cleared trackers
    regs_now.thr        = MagMax;
    regs_now.sag_hi     = '0;
    regs_now.sag_lo     = '0;
    regs_now.swell_hold = vssd_pkg::SwellHoldReset;
    regs_now.sag_hold   = vssd_pkg::SagHoldReset;
    regs_now.phases     = vssd_pkg::PhaseCountReset;
    swell_trk           = '0;
    sag_trk             = '0;

    // defaults: nothing can trip, not even full scale
    stim.push_back(win_row('0, '0, '0, 1'b1, '0));
    stim.push_back(win_row(MagMax, MagMax, MagMax, 1'b1, '0));
    // narrow settings, zero holds so every event ends on its first quiet window
    stim.push_back(reg_row(vssd_pkg::RegSwellThreshold, 1000));
    stim.push_back(reg_row(vssd_pkg::RegSagHigh, 500));
    stim.push_back(reg_row(vssd_pkg::RegSagLow, 100));
    stim.push_back(reg_row(vssd_pkg::RegSwellHold, 0));
    stim.push_back(reg_row(vssd_pkg::RegSagHold, 0));
    stim.push_back(reg_row(vssd_pkg::RegPhaseCount, 3));
    stim.push_back(win_row(1001, 0, 0, 1'b1, report(1, 1, 0, 0, 0, 0, 0, 0)));
    // threshold itself is no swell
    stim.push_back(win_row(1000, 0, 0, 1'b1, report(0, 0, 1, 1, 0, 0, 0, 0)));
    stim.push_back(win_row(0, 0, 300, 1'b1, report(0, 0, 0, 0, 1, 1, 0, 0)));
    // band bounds are exclusive
    stim.push_back(win_row(0, 500, 0, 1'b1, report(0, 0, 0, 0, 0, 0, 1, 1)));
    stim.push_back(win_row(100, 0, 0, 1'b1, '0));
    stim.push_back(win_row(0, 101, 0, 1'b1, report(0, 0, 0, 0, 1, 1, 0, 0)));
    stim.push_back(win_row(499, 0, MagMax, 1'b1, report(1, 1, 0, 0, 1, 0, 0, 0)));
    stim.push_back(win_row(0, 0, 0, 1'b1, report(0, 0, 1, 1, 0, 0, 1, 2)));
    // phase a only
    stim.push_back(reg_row(vssd_pkg::RegPhaseCount, 1));
    stim.push_back(win_row(0, MagMax, 300, 1'b1, '0));
    stim.push_back(win_row(MagMax, 0, 0, 1'b1, report(1, 1, 0, 0, 0, 0, 0, 0)));
    // no phase examined: the open swell runs down and ends
    stim.push_back(reg_row(vssd_pkg::RegPhaseCount, 0));
    stim.push_back(win_row(MagMax, MagMax, MagMax, 1'b1, report(0, 0, 1, 1, 0, 0, 0, 0)));
    stim.push_back(win_row(MagMax, 300, 300, 1'b1, '0));
    // hold of two, detection in the tail does not clear the post count
    stim.push_back(reg_row(vssd_pkg::RegPhaseCount, 2));
    stim.push_back(reg_row(vssd_pkg::RegSwellHold, 2));
    stim.push_back(reg_row(vssd_pkg::RegSagHold, 1023));
    stim.push_back(win_row(0, 2000, 0, 1'b0, '0));
    stim.push_back(win_row(0, 0, 0, 1'b0, '0));
    stim.push_back(win_row(2000, 0, 0, 1'b0, '0));
    stim.push_back(win_row(0, 0, 0, 1'b0, '0));
    stim.push_back(win_row(0, 0, 0, 1'b0, '0));
    stim.push_back(win_row(0, 0, 200, 1'b0, '0));
    stim.push_back(win_row(0, 250, 0, 1'b0, '0));
    // empty sag band while a sag is open, then let it end
    stim.push_back(reg_row(vssd_pkg::RegSagHigh, 500));
    stim.push_back(reg_row(vssd_pkg::RegSagLow, 500));
    stim.push_back(win_row(500, 499, 0, 1'b0, '0));
    stim.push_back(reg_row(vssd_pkg::RegSagHold, 0));
    stim.push_back(win_row(0, 0, 0, 1'b0, '0));
    stim.push_back(win_row(0, 501, 0, 1'b0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim[i]) begin
      row = stim[i];
      if (row.kind == ROW_REG) begin
        quiesce();
        write_reg(row.addr, row.value);
      end else begin
        send_word(row.a, row.b, row.c, row.typed, row.report);
      end
    end

    // random phases, each under fresh settings; the second and third use fixed extremes
    sent     = 0;
    phase_no = 0;
    while (sent < RandomWindows) begin
      r = random_regs();
      if (phase_no == 1) begin
        r = '{thr: MagMax, sag_hi: MagMax, sag_lo: '0, swell_hold: '1, sag_hold: '1,
              phases: 3};
      end else if (phase_no == 2) begin
        r = '{thr: '0, sag_hi: MagMax, sag_lo: MagMax, swell_hold: '0, sag_hold: '0,
              phases: 3};
      end
      program_regs(r);
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      phase_len    = $urandom_range(50, 150);
      run_left     = 0;
      for (int i = 0; i < int'(phase_len); i++) send_random_window();
      sent += phase_len;
      phase_no++;
    end

    quiesce();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
